>>> rtl/htbd_pkg.sv
// ----------------------------------------------------------------------------
// htbd_pkg: shared types and constants of the Huffman tree bit decoder
// Node entry layout, walk state encoding and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package htbd_pkg;

  localparam int unsigned IdxW          = 9;
  localparam int unsigned SymW          = 8;
  localparam int unsigned ByteBits      = 8;
  localparam int unsigned BitCntW       = $clog2(ByteBits + 1);
  localparam int unsigned NodeCountDef  = 512;
  localparam int unsigned ApbDataW      = 32;
  localparam int unsigned ApbAddrW      = 3;

  // register word index taken from paddr[2]
  localparam logic RegRootNode = 1'b0;

  typedef struct packed {
    logic [IdxW-1:0] left;
    logic [IdxW-1:0] right;
    logic            leaf;
    logic [SymW-1:0] sym;
  } node_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WALK,
    ST_FLUSH
  } walk_state_e;

endpackage

`default_nettype wire

>>> rtl/huffman_tree_bit_decoder_unit.sv
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder_unit: Huffman bit stream decoder, node table walk
// Loads a code tree one node per transfer and decodes compressed bytes one bit
// per cycle but for leaf refetches and output stalls, one symbol out per leaf.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  --------------------------------
//  input     in         in_valid_i / in_stall_o mode, node_index, left_child,
//                                               right_child, leaf_flag,
//                                               leaf_symbol, code_byte
//  output    out        out_valid_o/out_stall_i symbol, last_of_byte
//  config    in/out     APB (psel ... pready)   root_node at byte address 0
//
// A load transfer writes one node. A decode transfer holds the input
// stalled while the byte is walked, plus any output stall: one node
// table read per bit, each address taken from the entry the previous
// read returned, and a root refetch after a leaf.
// Reset clears the walk position, the root and the handshake state, not the
// table. One symbol is held back so last_of_byte can mark the final one.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_tree_bit_decoder_unit #(
  parameter int unsigned NODE_COUNT = htbd_pkg::NodeCountDef
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // input channel
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire                              mode_i,
  input  wire [htbd_pkg::IdxW-1:0]         node_index_i,
  input  wire [htbd_pkg::IdxW-1:0]         left_child_i,
  input  wire [htbd_pkg::IdxW-1:0]         right_child_i,
  input  wire                              leaf_flag_i,
  input  wire [htbd_pkg::SymW-1:0]         leaf_symbol_i,
  input  wire [htbd_pkg::ByteBits-1:0]     code_byte_i,
  // output channel
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [htbd_pkg::SymW-1:0]        symbol_o,
  output logic                             last_of_byte_o,
  // configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [htbd_pkg::ApbAddrW-1:0]     paddr,
  input  wire [htbd_pkg::ApbDataW-1:0]     pwdata,
  output logic [htbd_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready
);

  localparam int unsigned AW = $clog2(NODE_COUNT);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [htbd_pkg::IdxW-1:0] root_q;
  logic                      cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[2] == htbd_pkg::RegRootNode);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_we) begin
      root_q <= pwdata[htbd_pkg::IdxW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == htbd_pkg::RegRootNode) begin
      prdata = htbd_pkg::ApbDataW'(root_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Node table: one write port for loads, one registered read port for walks
  // ---------------------------------------------------------------------------
  htbd_pkg::node_t mem [NODE_COUNT];
  htbd_pkg::node_t rdata_q;
  logic            rzero_q;   // last read address was beyond the table
  logic            mem_we;
  logic [AW-1:0]   wr_addr;
  htbd_pkg::node_t wr_data;
  logic            rd_en;
  logic [htbd_pkg::IdxW-1:0] rd_idx;

  assign wr_addr = AW'(node_index_i);
  assign wr_data = '{left: left_child_i, right: right_child_i,
                     leaf: leaf_flag_i, sym: leaf_symbol_i};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[AW'(rd_idx)];
      rzero_q <= !(32'(rd_idx) < NODE_COUNT);
    end
  end

  // ---------------------------------------------------------------------------
  // Walk control
  // ---------------------------------------------------------------------------
  htbd_pkg::walk_state_e            state_q, state_d;
  logic [htbd_pkg::IdxW-1:0]        walk_q, walk_d;
  logic [htbd_pkg::ByteBits-1:0]    bits_q, bits_d;    // code byte, MSB first
  logic [htbd_pkg::BitCntW-1:0]     cnt_q, cnt_d;      // bits still to walk
  logic                             test_q, test_d;    // entry is a child
  logic                             pend_valid_q, pend_valid_d;
  logic [htbd_pkg::SymW-1:0]        pend_sym_q, pend_sym_d;
  logic                             out_valid_q, out_valid_d;
  logic [htbd_pkg::SymW-1:0]        out_sym_q;
  logic                             out_last_q;
  logic                             out_load, out_last_d;
  logic                             out_free;
  logic                             in_xfer;
  htbd_pkg::node_t                  node_eff;
  logic [htbd_pkg::IdxW-1:0]        child;

  assign in_stall_o = (state_q != htbd_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign mem_we     = in_xfer && !mode_i && (32'(node_index_i) < NODE_COUNT);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign node_eff   = rzero_q ? '0 : rdata_q;
  assign child      = bits_q[htbd_pkg::ByteBits-1] ? node_eff.right : node_eff.left;

  always_comb begin
    state_d      = state_q;
    walk_d       = walk_q;
    bits_d       = bits_q;
    cnt_d        = cnt_q;
    test_d       = test_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    rd_en        = 1'b0;
    rd_idx       = walk_q;
    out_load     = 1'b0;
    out_last_d   = 1'b0;

    unique case (state_q)
      htbd_pkg::ST_IDLE: begin
        if (in_xfer && mode_i) begin
          bits_d  = code_byte_i;
          cnt_d   = htbd_pkg::BitCntW'(htbd_pkg::ByteBits);
          state_d = htbd_pkg::ST_FETCH;
        end
      end

      htbd_pkg::ST_FETCH: begin
        // read the entry at the walk position; it is not tested as a leaf
        rd_en   = 1'b1;
        rd_idx  = walk_q;
        test_d  = 1'b0;
        state_d = htbd_pkg::ST_WALK;
      end

      htbd_pkg::ST_WALK: begin
        if (test_q && node_eff.leaf) begin
          // hold while an older symbol cannot move out
          if (!pend_valid_q || out_free) begin
            out_load     = pend_valid_q;
            pend_valid_d = 1'b1;
            pend_sym_d   = node_eff.sym;
            walk_d       = root_q;
            state_d      = (cnt_q == '0) ? htbd_pkg::ST_FLUSH : htbd_pkg::ST_FETCH;
          end
        end else if (cnt_q == '0) begin
          state_d = htbd_pkg::ST_FLUSH;
        end else begin
          // advance one bit: step to the child and read it
          rd_en  = 1'b1;
          rd_idx = child;
          walk_d = child;
          bits_d = {bits_q[htbd_pkg::ByteBits-2:0], 1'b0};
          cnt_d  = cnt_q - 1'b1;
          test_d = 1'b1;
        end
      end

      htbd_pkg::ST_FLUSH: begin
        // release the held symbol as the last one of this byte
        if (!pend_valid_q) begin
          state_d = htbd_pkg::ST_IDLE;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = htbd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = htbd_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= htbd_pkg::ST_IDLE;
      walk_q       <= '0;
      cnt_q        <= '0;
      test_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      walk_q       <= walk_d;
      cnt_q        <= cnt_d;
      test_q       <= test_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q     <= bits_d;
    pend_sym_q <= pend_sym_d;
    if (out_load) begin
      out_sym_q  <= pend_sym_q;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign symbol_o       = out_sym_q;
  assign last_of_byte_o = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= htbd_pkg::BitCntW'(htbd_pkg::ByteBits))
    else $error("bit count out of range");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == htbd_pkg::ST_IDLE |-> !pend_valid_q)
    else $error("symbol left pending after byte end");

  a_write_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == htbd_pkg::ST_IDLE)
    else $error("node table written during a walk");

  a_out_from_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pend_valid_q))
    else $error("output loaded without a pending symbol");

  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == htbd_pkg::ST_FLUSH && out_load) |=> out_last_q)
    else $error("byte end symbol not marked last");

endmodule

`default_nettype wire
